// File: design/swsp_pkg.sv
// Package for the shell word splitter: quote modes, event codes, byte codes
// and the parser state record. It has no dependencies.
package swsp_pkg;

	// Quoting context of the parser. The unused fourth code acts as unquoted.
	typedef enum logic [1:0] {
		QM_UNQUOTED = 2'd0,
		QM_DOUBLE   = 2'd1,
		QM_SINGLE   = 2'd2
	} quote_mode_t;

	// Kind of result beat.
	typedef enum logic [1:0] {
		EV_BYTE      = 2'd0,
		EV_END_OK    = 2'd1,
		EV_END_ESC   = 2'd2,
		EV_END_QUOTE = 2'd3
	} event_t;

	// Bytes with a special meaning to the parser.
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// Parser flags, without the line count whose width is a parameter.
	typedef struct packed {
		quote_mode_t quote_mode;
		logic        escape_pending;
		logic        in_comment;
		logic        in_word;
	} swsp_state_t;

	localparam swsp_state_t STATE_RESET = '{
		quote_mode:     QM_UNQUOTED,
		escape_pending: 1'b0,
		in_comment:     1'b0,
		in_word:        1'b0
	};

endpackage

// File: design/swsp_if.sv
// Valid/ready channel interfaces for the shell word splitter.
// Depends on swsp_pkg for the event code type.
interface swsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_file;

	modport source (output valid, output byte_in, output end_of_file, input ready);
	modport sink (input valid, input byte_in, input end_of_file, output ready);
endinterface

interface swsp_out_if
	import swsp_pkg::*;
#(
	parameter int LINE_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	event_t                event_res;
	logic                  starts_word;
	logic                  has_byte;
	logic [7:0]            byte_out;
	logic [LINE_WIDTH-1:0] line_number;

	modport source (output valid, output event_res, output starts_word, output has_byte,
		output byte_out, output line_number, input ready);
	modport sink (input valid, input event_res, input starts_word, input has_byte,
		input byte_out, input line_number, output ready);
endinterface

// File: design/swsp_step.sv
// Next-state and result logic of the shell word splitter for one beat.
// Purely combinational; depends on swsp_pkg.
module swsp_step
	import swsp_pkg::*;
#(
	parameter int LINE_WIDTH = 32
) (
	input  logic [7:0]            byte_in,
	input  logic                  end_of_file,
	input  swsp_state_t           state_q,
	input  logic [LINE_WIDTH-1:0] line_q,
	output swsp_state_t           state_d,
	output logic [LINE_WIDTH-1:0] line_d,
	output event_t                event_res,
	output logic                  starts_word,
	output logic                  has_byte,
	output logic [7:0]            byte_out,
	output logic [LINE_WIDTH-1:0] line_number
);

	logic                  unquoted;
	logic                  blank;
	logic                  done;
	logic                  count;
	logic [LINE_WIDTH-1:0] line_inc;

	// Blanks are space, tab, newline, vertical tab, form feed and return.
	always_comb begin
		blank = (byte_in == CH_SPACE) || (byte_in inside {[CH_TAB:CH_CR]});
	end

	// Saturating line counter increment.
	assign line_inc = (line_q != '1) ? line_q + 1'b1 : line_q;

	// Parser flags for a byte beat.
	always_comb begin
		state_d     = state_q;
		starts_word = 1'b0;
		has_byte    = 1'b0;
		byte_out    = '0;
		count       = 1'b0;
		done        = 1'b0;
		unquoted    = !(state_q.quote_mode == QM_DOUBLE || state_q.quote_mode == QM_SINGLE);

		// Comments and blanks only matter outside quotes and escapes.
		if (unquoted && !state_q.escape_pending) begin
			if (state_q.in_comment) begin
				if (byte_in == CH_NL) begin
					state_d.in_comment = 1'b0;
					count              = 1'b1;
				end
				done = 1'b1;
			end else if (byte_in == CH_HASH && !state_q.in_word) begin
				state_d.in_comment = 1'b1;
				done               = 1'b1;
			end else if (blank) begin
				state_d.in_word = 1'b0;
				count           = (byte_in == CH_NL);
				done            = 1'b1;
			end
		end

		// Backslash-newline joins lines and adds nothing.
		if (!done && state_q.escape_pending && byte_in == CH_NL) begin
			count                  = 1'b1;
			state_d.escape_pending = 1'b0;
			done                   = 1'b1;
		end

		// Word content: escaped byte, quote change or literal byte.
		if (!done) begin
			if (!state_q.in_word) begin
				state_d.in_word = 1'b1;
				starts_word     = 1'b1;
			end
			if (state_q.escape_pending) begin
				has_byte               = 1'b1;
				byte_out               = byte_in;
				state_d.escape_pending = 1'b0;
			end else begin
				case (state_q.quote_mode)
					QM_SINGLE: begin
						if (byte_in == CH_SQUOTE) begin
							state_d.quote_mode = QM_UNQUOTED;
						end else begin
							has_byte = 1'b1;
							byte_out = byte_in;
						end
					end
					QM_DOUBLE: begin
						if (byte_in == CH_BSLASH) begin
							state_d.escape_pending = 1'b1;
						end else if (byte_in == CH_DQUOTE) begin
							state_d.quote_mode = QM_UNQUOTED;
						end else begin
							has_byte = 1'b1;
							byte_out = byte_in;
						end
					end
					default: begin
						if (byte_in == CH_BSLASH) begin
							state_d.escape_pending = 1'b1;
						end else if (byte_in == CH_DQUOTE) begin
							state_d.quote_mode = QM_DOUBLE;
						end else if (byte_in == CH_SQUOTE) begin
							state_d.quote_mode = QM_SINGLE;
						end else begin
							has_byte = 1'b1;
							byte_out = byte_in;
						end
					end
				endcase
				count = (byte_in == CH_NL);
			end
		end

		// End beat: report status, then return to the reset state.
		if (end_of_file) begin
			state_d     = STATE_RESET;
			starts_word = 1'b0;
			has_byte    = 1'b0;
			byte_out    = '0;
		end
	end

	// Status of an end beat; a dangling backslash outranks an open quote.
	always_comb begin
		if (!end_of_file) begin
			event_res = EV_BYTE;
		end else if (state_q.escape_pending) begin
			event_res = EV_END_ESC;
		end else if (!unquoted) begin
			event_res = EV_END_QUOTE;
		end else begin
			event_res = EV_END_OK;
		end
	end

	// The end beat reports the count before it is cleared.
	assign line_d      = end_of_file ? '0 : (count ? line_inc : line_q);
	assign line_number = end_of_file ? line_q : line_d;

endmodule

// File: design/shell_word_splitter_unit.sv
// Shell word splitter top level. A beat accepted into the input register has its
// result loaded through swsp_step into the result register (input register, then
// result register) once stage 2 can load. While the result side does not stall,
// it takes one byte or end beat per cycle; the parser state loop closes through swsp_step.
// Stalls on the result side back up one stage. Reset clears the parser flags, the line
// count and both valid flags. Depends on swsp_pkg, swsp_if and swsp_step.
module shell_word_splitter_unit
	import swsp_pkg::*;
#(
	parameter int LINE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	swsp_in_if.sink     byte_ch,
	swsp_out_if.source  result_ch
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eof_s1;
	logic                  valid_s2;
	event_t                event_s2;
	logic                  starts_s2;
	logic                  has_s2;
	logic [7:0]            byte_s2;
	logic [LINE_WIDTH-1:0] line_s2;
	swsp_state_t           state_q;
	swsp_state_t           state_d;
	logic [LINE_WIDTH-1:0] line_q;
	logic [LINE_WIDTH-1:0] line_d;
	event_t                event_d;
	logic                  starts_d;
	logic                  has_d;
	logic [7:0]            byte_d;
	logic [LINE_WIDTH-1:0] line_num_d;
	logic                  advance;
	logic                  take_in;

	// Stage 2 can load when it is empty or its beat leaves now.
	assign advance       = !valid_s2 || result_ch.ready;
	assign byte_ch.ready = !valid_s1 || advance;
	assign take_in       = byte_ch.valid && byte_ch.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= byte_ch.byte_in;
			eof_s1  <= byte_ch.end_of_file;
		end
	end

	swsp_step #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_step (
		.byte_in     (byte_s1),
		.end_of_file (eof_s1),
		.state_q     (state_q),
		.line_q      (line_q),
		.state_d     (state_d),
		.line_d      (line_d),
		.event_res   (event_d),
		.starts_word (starts_d),
		.has_byte    (has_d),
		.byte_out    (byte_d),
		.line_number (line_num_d)
	);

	// Parser state and result register update when stage 1 moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_RESET;
			line_q   <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_d;
				line_q  <= line_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			event_s2  <= event_d;
			starts_s2 <= starts_d;
			has_s2    <= has_d;
			byte_s2   <= byte_d;
			line_s2   <= line_num_d;
		end
	end

	assign result_ch.valid       = valid_s2;
	assign result_ch.event_res   = event_s2;
	assign result_ch.starts_word = starts_s2;
	assign result_ch.has_byte    = has_s2;
	assign result_ch.byte_out    = byte_s2;
	assign result_ch.line_number = line_s2;

	// A pending escape always sits inside an open word.
	a_escape_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.escape_pending |-> state_q.in_word)
		else $error("escape pending outside a word");

	// An end beat returns the parser to its reset state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && eof_s1 |=> state_q == STATE_RESET && line_q == '0)
		else $error("end beat did not clear the parser state");

	// The line count never drops on a byte beat.
	a_line_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && !eof_s1 |=> line_q >= $past(line_q))
		else $error("line count decreased on a byte beat");

	// End beats carry no word byte.
	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && event_s2 != EV_BYTE |-> !has_s2 && !starts_s2)
		else $error("end beat carries word data");

endmodule
